FILE: rtl/core/frac_pkg.sv
// Package for the fraction arithmetic reduce block.
// Holds opcodes, widths and the front-to-back queue entry type; no dependencies.
package frac_pkg;
	localparam int InWidth  = 16;
	localparam int NumWidth = 32;
	localparam int DenWidth = 31;
	localparam int MagWidth = 32;
	localparam int QDepth   = 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// One classified item: magnitudes of the exact result plus its sign and kind.
	typedef struct packed {
		logic                err;
		logic                zero;
		logic                neg;
		logic [MagWidth-1:0] mag_num;
		logic [MagWidth-1:0] mag_den;
	} work_t;
endpackage

FILE: rtl/core/frac_front.sv
// Front part: accepts an item, forms the unreduced product terms and classifies it.
// Depends on frac_pkg. Two registered stages: products, then sum and sign.
module frac_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     opcode,
	input  logic signed [frac_pkg::InWidth-1:0] n1,
	input  logic [frac_pkg::InWidth-2:0]   d1,
	input  logic signed [frac_pkg::InWidth-1:0] n2,
	input  logic [frac_pkg::InWidth-2:0]   d2,
	output logic                           out_valid,
	input  logic                           out_ready,
	output frac_pkg::work_t                out_work
);
	logic        v_s1, v_s2;
	logic        err_s1;
	logic [1:0]  op_s1;
	logic signed [32:0] pa_s1, pb_s1;
	logic [31:0] den_s1;
	frac_pkg::work_t w_s2;
	logic        adv1, adv2;
	logic signed [33:0] sum;
	logic [33:0] mag;
	logic signed [16:0] an2;

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;
	assign an2 = n2[frac_pkg::InWidth-1] ? -17'(n2) : 17'(n2);

	// Stage one: the multiplications.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			op_s1  <= opcode;
			err_s1 <= (d1 == '0) || (d2 == '0) ||
				(opcode == frac_pkg::OP_DIV && n2 == '0);
			unique case (frac_pkg::op_t'(opcode))
				frac_pkg::OP_ADD, frac_pkg::OP_SUB: begin
					pa_s1  <= 33'(n1 * $signed({1'b0, d2}));
					pb_s1  <= 33'(n2 * $signed({1'b0, d1}));
					den_s1 <= 32'(d1 * d2);
				end
				frac_pkg::OP_MUL: begin
					pa_s1  <= 33'(n1 * n2);
					pb_s1  <= '0;
					den_s1 <= 32'(d1 * d2);
				end
				default: begin
					pa_s1  <= n2[frac_pkg::InWidth-1] ?
						-33'(n1 * $signed({1'b0, d2})) : 33'(n1 * $signed({1'b0, d2}));
					pb_s1  <= '0;
					den_s1 <= 32'(d1 * an2[15:0]);
				end
			endcase
		end
	end

	// Stage two: combine, take magnitude and classify.
	always_comb begin
		sum = (op_s1 == frac_pkg::OP_SUB) ? 34'(pa_s1) - 34'(pb_s1) : 34'(pa_s1) + 34'(pb_s1);
		mag = sum[33] ? 34'(-sum) : 34'(sum);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			w_s2.err     <= err_s1;
			w_s2.zero    <= (sum == '0);
			w_s2.neg     <= sum[33];
			w_s2.mag_num <= mag[31:0];
			w_s2.mag_den <= den_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_work  = w_s2;
endmodule

FILE: rtl/core/frac_queue.sv
// Short queue between the front and back parts.
// Depends on frac_pkg for the entry type and depth.
module frac_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  frac_pkg::work_t wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output frac_pkg::work_t rd_data
);
	frac_pkg::work_t mem_q [frac_pkg::QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'(frac_pkg::QDepth);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

FILE: rtl/core/frac_back.sv
// Back part: binary GCD, then two restoring divisions by the GCD, then the output register.
// Errors and zero results skip straight to the output register. Depends on frac_pkg.
module frac_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  frac_pkg::work_t                in_work,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [frac_pkg::NumWidth-1:0]  out_num,
	output logic [frac_pkg::DenWidth-1:0]  out_den,
	output logic                           out_err
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_GCD  = 5'b00010,
		S_DIVN = 5'b00100,
		S_DIVD = 5'b01000,
		S_OUT  = 5'b10000
	} st_t;

	st_t         st_q;
	logic [31:0] a_q, b_q, g_q, nq_q, dq_q;
	logic [31:0] quo_q, rem_q, dvd_q;
	logic [5:0]  sh_q, cnt_q;
	logic        neg_q;
	logic [31:0] diff;
	logic [32:0] trial;
	logic [31:0] onum;

	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign trial = {rem_q, dvd_q[31]} - {1'b0, g_q};

	// Sequencer: one GCD step or one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			unique case (st_q)
				S_IDLE: if (in_valid) begin
					st_q <= (in_work.err || in_work.zero) ? S_OUT : S_GCD;
				end
				S_GCD: if (b_q == '0) st_q <= S_DIVN;
				S_DIVN: if (cnt_q == 6'd31) st_q <= S_DIVD;
				S_DIVD: if (cnt_q == 6'd31) st_q <= S_OUT;
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb diff = (a_q > b_q) ? a_q - b_q : b_q - a_q;

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: if (in_valid) begin
				a_q   <= in_work.mag_num;
				b_q   <= in_work.mag_den;
				dvd_q <= in_work.mag_num;
				neg_q <= in_work.neg;
				sh_q  <= '0;
				cnt_q <= '0;
				rem_q <= '0;
				if (in_work.err) begin
					nq_q <= '0; dq_q <= '0;
				end else if (in_work.zero) begin
					nq_q <= '0; dq_q <= 32'd1;
				end else begin
					dq_q <= in_work.mag_den;
				end
				out_err <= in_work.err;
			end
			S_GCD: begin
				// Stein's algorithm; on finish, g = a << shift.
				if (b_q == '0) begin
					g_q <= a_q << sh_q;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1; b_q <= b_q >> 1; sh_q <= sh_q + 6'd1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else begin
					a_q <= (a_q < b_q) ? a_q : b_q;
					b_q <= diff >> 1;
				end
			end
			S_DIVN, S_DIVD: begin
				quo_q <= {quo_q[30:0], !trial[32]};
				if (cnt_q == 6'd31) begin
					// Last quotient bit: store the quotient and set up the next pass.
					cnt_q <= '0;
					rem_q <= '0;
					if (st_q == S_DIVN) begin
						nq_q  <= {quo_q[30:0], !trial[32]};
						dvd_q <= dq_q;
					end else begin
						dq_q <= {quo_q[30:0], !trial[32]};
					end
				end else begin
					rem_q <= trial[32] ? {rem_q[30:0], dvd_q[31]} : trial[31:0];
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q + 6'd1;
				end
			end
			default: ;
		endcase
	end

	assign onum = neg_q ? -nq_q : nq_q;
	assign out_num = onum;
	assign out_den = dq_q[30:0];
endmodule

FILE: rtl/core/fraction_arithmetic_reduce.sv
// Fraction arithmetic with reduction to lowest terms (top level).
// Path: the front stages, the queue, binary GCD steps, then two 32-bit restoring
// divisions by the GCD and the output state.
// The back end takes one item per pass; errors and zeros skip to the output state.
// Reset: arst_n asynchronous, active low, clears all valid and state bits.
module fraction_arithmetic_reduce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode[1:0], first_numerator[17:2], first_denominator[32:18],
	// second_numerator[48:33], second_denominator[63:49]
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_numerator[31:0], result_denominator[62:32]
	output logic [63:0] m_axis_tdata,
	// error_flag
	output logic        m_axis_tuser
);
	logic            f_valid, f_ready, q_valid, q_ready;
	frac_pkg::work_t f_work, q_work;
	logic [31:0]     r_num;
	logic [30:0]     r_den;

	frac_front u_front (
		.clk, .arst_n,
		.in_valid (s_axis_tvalid), .in_ready (s_axis_tready),
		.opcode   (s_axis_tdata[1:0]),
		.n1       (s_axis_tdata[17:2]),
		.d1       (s_axis_tdata[32:18]),
		.n2       (s_axis_tdata[48:33]),
		.d2       (s_axis_tdata[63:49]),
		.out_valid (f_valid), .out_ready (f_ready), .out_work (f_work)
	);

	frac_queue u_queue (
		.clk, .arst_n,
		.wr_valid (f_valid), .wr_ready (f_ready), .wr_data (f_work),
		.rd_valid (q_valid), .rd_ready (q_ready), .rd_data (q_work)
	);

	frac_back u_back (
		.clk, .arst_n,
		.in_valid (q_valid), .in_ready (q_ready), .in_work (q_work),
		.out_valid (m_axis_tvalid), .out_ready (m_axis_tready),
		.out_num (r_num), .out_den (r_den), .out_err (m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, r_den, r_num};

	// An error result always carries 0/0.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[62:0] == '0)
		else $error("error result not 0/0");
	// A good result never has a zero denominator.
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[62:32] != '0)
		else $error("zero denominator on good result");
	// The queue never reports both full and empty.
	a_q_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(!f_ready && !q_valid))
		else $error("queue count inconsistent");
endmodule
